### rtl/core/fqp_pkg.sv
// Shared types and codes for the FIFO queue with promote.
// Request and response structs, request and status codes, controller/datapath link.
// No dependencies.
`timescale 1ns / 1ps

package fqp_pkg;

  localparam logic [1:0] REQ_APPEND  = 2'd0;
  localparam logic [1:0] REQ_POP     = 2'd1;
  localparam logic [1:0] REQ_PROMOTE = 2'd2;
  localparam logic [1:0] REQ_SEARCH  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam int KEY_W = 16;
  localparam int PAY_W = 8;
  localparam int ENTRY_W = KEY_W + PAY_W;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] entry_key;
    logic [PAY_W-1:0] entry_payload;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] result_key;
    logic [PAY_W-1:0] result_payload;
    logic [3:0]       result_position;
  } rsp_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_APPEND,
    OP_POP_RD,
    OP_POP_DAT,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_SHIFT_INIT,
    OP_SHIFT,
    OP_HEAD_WR,
    OP_RESULT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic       below_two;
    logic       promote;
    logic       hit;
    logic       scan_end;
    logic       shift_end;
    logic       out_free;
  } stat_t;

endpackage

### rtl/core/fqp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module fqp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/fqp_ctrl.sv
// Controller state machine for the FIFO queue with promote.
// Sequences each request through the datapath; depends on fqp_pkg.
`timescale 1ns / 1ps

module fqp_ctrl import fqp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_type,
  output logic       req_stall,
  input  stat_t      stat,
  output cmd_t       cmd
);

  typedef enum logic [9:0] {
    S_IDLE       = 10'b00_0000_0001,
    S_APPEND     = 10'b00_0000_0010,
    S_POP_RD     = 10'b00_0000_0100,
    S_POP_DAT    = 10'b00_0000_1000,
    S_SCAN_INIT  = 10'b00_0001_0000,
    S_SCAN       = 10'b00_0010_0000,
    S_SHIFT_INIT = 10'b00_0100_0000,
    S_SHIFT      = 10'b00_1000_0000,
    S_HEAD_WR    = 10'b01_0000_0000,
    S_RESULT     = 10'b10_0000_0000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] res_st;
  logic [1:0] res_st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      res_st <= ST_OK;
    end else begin
      state  <= state_next;
      res_st <= res_st_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    res_st_next = res_st;
    cmd.op      = OP_NONE;
    cmd.status  = res_st;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op = OP_LOAD;
          case (req_type)
            REQ_APPEND: state_next = S_APPEND;
            REQ_POP:    state_next = S_POP_RD;
            default:    state_next = S_SCAN_INIT;
          endcase
        end
      end
      S_APPEND: begin
        state_next = S_RESULT;
        if (stat.full) begin
          res_st_next = ST_FULL;
        end else begin
          cmd.op      = OP_APPEND;
          res_st_next = ST_OK;
        end
      end
      S_POP_RD: begin
        if (stat.empty) begin
          res_st_next = ST_EMPTY;
          state_next  = S_RESULT;
        end else begin
          cmd.op     = OP_POP_RD;
          state_next = S_POP_DAT;
        end
      end
      S_POP_DAT: begin
        cmd.op      = OP_POP_DAT;
        res_st_next = ST_OK;
        state_next  = S_RESULT;
      end
      S_SCAN_INIT: begin
        if (stat.promote && stat.below_two) begin
          res_st_next = ST_NOTFOUND;
          state_next  = S_RESULT;
        end else begin
          cmd.op     = OP_SCAN_INIT;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (stat.hit) begin
          if (stat.promote) begin
            state_next = S_SHIFT_INIT;
          end else begin
            res_st_next = ST_OK;
            state_next  = S_RESULT;
          end
        end else if (stat.scan_end) begin
          res_st_next = ST_NOTFOUND;
          state_next  = S_RESULT;
        end
      end
      S_SHIFT_INIT: begin
        cmd.op     = OP_SHIFT_INIT;
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.op = OP_SHIFT;
        if (stat.shift_end) begin
          state_next = S_HEAD_WR;
        end
      end
      S_HEAD_WR: begin
        cmd.op      = OP_HEAD_WR;
        res_st_next = ST_OK;
        state_next  = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.op     = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/fqp_dpath.sv
// Datapath for the FIFO queue with promote: circular entry store, scan and shift
// pointers, found-entry registers and the response register. Depends on fqp_pkg, fqp_ram.
`timescale 1ns / 1ps

module fqp_dpath import fqp_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  req_t  req_data,
  input  cmd_t  cmd,
  output stat_t stat,
  output logic  rsp_valid,
  input  logic  rsp_stall,
  output rsp_t  rsp_data
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW:0]   DEPTH_S   = (CW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] HEAD_LAST = AW'(QUEUE_DEPTH - 1);

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] idx);
    logic [CW:0] s;
    s = (CW + 1)'(hd) + (CW + 1)'(idx);
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[AW-1:0];
  endfunction

  logic [AW-1:0]      head;
  logic [CW-1:0]      count;
  req_t               req_q;
  logic [CW-1:0]      rd_idx;
  logic               rd_live;
  logic [CW-1:0]      dat_idx;
  logic               dat_live;
  logic [KEY_W-1:0]   found_key;
  logic [PAY_W-1:0]   found_pay;
  logic [CW-1:0]      found_pos;
  logic [CW+3:0]      pos_ext;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;
  logic               re;
  logic [AW-1:0]      raddr;
  logic [ENTRY_W-1:0] rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [PAY_W-1:0]   rd_pay;
  logic               rd_more;
  logic               hit;

  fqp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_key  = rdata[ENTRY_W-1:PAY_W];
  assign rd_pay  = rdata[PAY_W-1:0];
  assign rd_more = (rd_idx < count);
  assign hit     = dat_live && (rd_key == req_q.entry_key);
  assign pos_ext = (CW + 4)'(found_pos);

  always_comb begin
    stat.empty     = (count == '0);
    stat.full      = (count == DEPTH_C);
    stat.below_two = (count < CW'(2));
    stat.promote   = (req_q.req_type == REQ_PROMOTE);
    stat.hit       = hit;
    stat.scan_end  = !dat_live && !rd_more;
    stat.shift_end = !rd_live && !dat_live;
    stat.out_free  = !rsp_valid || !rsp_stall;
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    re    = 1'b0;
    raddr = '0;
    case (cmd.op)
      OP_APPEND: begin
        we    = 1'b1;
        waddr = phys(head, count);
        wdata = {req_q.entry_key, req_q.entry_payload};
      end
      OP_POP_RD: begin
        re    = 1'b1;
        raddr = head;
      end
      OP_SCAN: begin
        re    = rd_more;
        raddr = phys(head, rd_idx);
      end
      OP_SHIFT: begin
        re    = rd_live;
        raddr = phys(head, rd_idx);
        we    = dat_live;
        waddr = phys(head, dat_idx + CW'(1));
        wdata = rdata;
      end
      OP_HEAD_WR: begin
        we    = 1'b1;
        waddr = head;
        wdata = {found_key, found_pay};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      rd_live   <= 1'b0;
      dat_live  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (cmd.op != OP_RESULT)) begin
        rsp_valid <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          req_q     <= req_data;
          found_key <= '0;
          found_pay <= '0;
          found_pos <= '0;
        end
        OP_APPEND: begin
          count <= count + CW'(1);
        end
        OP_POP_DAT: begin
          found_key <= rd_key;
          found_pay <= rd_pay;
          found_pos <= '0;
          head      <= (head == HEAD_LAST) ? '0 : head + AW'(1);
          count     <= count - CW'(1);
        end
        OP_SCAN_INIT: begin
          rd_idx   <= (req_q.req_type == REQ_PROMOTE) ? CW'(1) : '0;
          dat_live <= 1'b0;
        end
        OP_SCAN: begin
          if (rd_more) begin
            rd_idx   <= rd_idx + CW'(1);
            dat_idx  <= rd_idx;
            dat_live <= 1'b1;
          end else begin
            dat_live <= 1'b0;
          end
          if (hit) begin
            found_key <= rd_key;
            found_pay <= rd_pay;
            found_pos <= dat_idx;
          end
        end
        OP_SHIFT_INIT: begin
          rd_idx   <= found_pos - CW'(1);
          rd_live  <= 1'b1;
          dat_live <= 1'b0;
        end
        OP_SHIFT: begin
          if (rd_live) begin
            dat_idx  <= rd_idx;
            dat_live <= 1'b1;
            if (rd_idx == '0) begin
              rd_live <= 1'b0;
            end else begin
              rd_idx <= rd_idx - CW'(1);
            end
          end else begin
            dat_live <= 1'b0;
          end
        end
        OP_RESULT: begin
          rsp_valid                <= 1'b1;
          rsp_data.status          <= cmd.status;
          rsp_data.result_key      <= (cmd.status == ST_OK) ? found_key : '0;
          rsp_data.result_payload  <= (cmd.status == ST_OK) ? found_pay : '0;
          rsp_data.result_position <= (cmd.status == ST_OK) ? pos_ext[3:0] : 4'd0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/core/fifo_queue_with_promote_unit.sv
// FIFO queue with promote, top level: controller and datapath.
// Depends on fqp_pkg, fqp_ctrl, fqp_dpath, fqp_ram.
//
// Holds up to QUEUE_DEPTH entries (16-bit key, 8-bit payload) in one circular
// single-write, single-read RAM. Requests are taken one at a time; each returns
// exactly one response through a response register, so a new request may be
// accepted while the previous response waits. Search walks the queue from the head at
// one entry a cycle. Promote scans from position 1 the same way, then moves the
// entries ahead of the match back one slot at one entry a cycle and writes the
// match at the head. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module fifo_queue_with_promote_unit import fqp_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  cmd_t  cmd;
  stat_t stat;

  fqp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_data.req_type),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  fqp_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule

### verif/fifo_queue_with_promote_unit_test.sv
// Testbench for fifo_queue_with_promote_unit: directed corner requests, then random ones.
// Checks every response against a built-in predictor of the queue.
// Depends on fqp_pkg and the fifo_queue_with_promote_unit RTL.
`timescale 1ns / 1ps

module fifo_queue_with_promote_unit_test;
  import fqp_pkg::*;

  localparam int DEPTH = 16;
  localparam int RANDOM_REQUESTS = 750;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PERCENT = 23;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_data;

  req_t request_backlog[$];
  rsp_t expected_responses[$];

  logic [KEY_W-1:0] held_keys[DEPTH];
  logic [PAY_W-1:0] held_payloads[DEPTH];
  int held = 0;

  int issued = 0;
  int errors = 0;
  int cycles = 0;
  logic calm;

  fifo_queue_with_promote_unit #(.QUEUE_DEPTH(DEPTH)) u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data(rsp_data)
  );

  always #1 clk = ~clk;

  assign calm = (issued >= 300) && (issued < 420);

  function automatic rsp_t apply_request(req_t rq);
    rsp_t r;
    int pos;
    int i;
    logic [KEY_W-1:0] k;
    logic [PAY_W-1:0] p;
    r = '0;
    pos = -1;
    case (rq.req_type)
      REQ_APPEND: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          held_keys[held] = rq.entry_key;
          held_payloads[held] = rq.entry_payload;
          held++;
          r.status = ST_OK;
        end
      end
      REQ_POP: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_OK;
          r.result_key = held_keys[0];
          r.result_payload = held_payloads[0];
          for (i = 1; i < held; i++) begin
            held_keys[i-1] = held_keys[i];
            held_payloads[i-1] = held_payloads[i];
          end
          held--;
        end
      end
      REQ_PROMOTE: begin
        for (i = 1; i < held; i++)
          if (pos < 0 && held_keys[i] == rq.entry_key) pos = i;
        if (pos < 1) begin
          r.status = ST_NOTFOUND;
        end else begin
          k = held_keys[pos];
          p = held_payloads[pos];
          for (i = pos; i > 0; i--) begin
            held_keys[i] = held_keys[i-1];
            held_payloads[i] = held_payloads[i-1];
          end
          held_keys[0] = k;
          held_payloads[0] = p;
          r.status = ST_OK;
          r.result_key = k;
          r.result_payload = p;
          r.result_position = 4'(pos);
        end
      end
      default: begin
        for (i = 0; i < held; i++)
          if (pos < 0 && held_keys[i] == rq.entry_key) pos = i;
        if (pos < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.status = ST_OK;
          r.result_key = held_keys[pos];
          r.result_payload = held_payloads[pos];
          r.result_position = 4'(pos);
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 75) return KEY_W'($urandom_range(0, 11));
    return KEY_W'($urandom_range(0, 65535));
  endfunction

  task automatic add_request(logic [1:0] kind, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
    req_t rq;
    rq.req_type = kind;
    rq.entry_key = k;
    rq.entry_payload = p;
    request_backlog.push_back(rq);
  endtask

  function automatic void check_field(string label, logic [KEY_W-1:0] want,
                                      logic [KEY_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      errors++;
    end
  endfunction

  // Driver: predict on acceptance, then present the next request or idle.
  always @(posedge clk) begin : driver
    req_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_responses.push_back(apply_request(req_data));
        issued++;
      end
      if (!req_valid || !req_stall) begin
        if (request_backlog.size() == 0 ||
            (!calm && $urandom_range(0, 99) < IDLE_PERCENT)) begin
          req_valid <= 1'b0;
        end else begin
          nxt = request_backlog.pop_front();
          req_data <= nxt;
          req_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: compare each accepted response with the oldest prediction.
  always @(posedge clk) begin : monitor
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_responses.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual %h", $time, rsp_data);
          errors++;
        end else begin
          want = expected_responses.pop_front();
          check_field("status", KEY_W'(want.status), KEY_W'(rsp_data.status));
          check_field("result_key", want.result_key, rsp_data.result_key);
          check_field("result_payload", KEY_W'(want.result_payload),
                      KEY_W'(rsp_data.result_payload));
          check_field("result_position", KEY_W'(want.result_position),
                      KEY_W'(rsp_data.result_position));
        end
      end
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    int roll;
    logic filling;
    logic [1:0] kind;

    // Empty queue, single entry and head-only cases.
    add_request(REQ_POP, 16'hFFFF, 8'hFF);
    add_request(REQ_SEARCH, 16'h0000, 8'h00);
    add_request(REQ_PROMOTE, 16'h0000, 8'h00);
    add_request(REQ_APPEND, 16'h0000, 8'h00);
    add_request(REQ_PROMOTE, 16'h0000, 8'h00);
    add_request(REQ_SEARCH, 16'h0000, 8'h00);
    add_request(REQ_APPEND, 16'hFFFF, 8'hFF);
    add_request(REQ_PROMOTE, 16'hFFFF, 8'h00);
    add_request(REQ_PROMOTE, 16'hFFFF, 8'h00);
    // Duplicate keys: first match wins.
    add_request(REQ_APPEND, 16'hA5A5, 8'h5A);
    add_request(REQ_APPEND, 16'hA5A5, 8'hA5);
    add_request(REQ_SEARCH, 16'hA5A5, 8'h00);
    add_request(REQ_PROMOTE, 16'h5A5A, 8'h00);
    // Fill to capacity, overflow, then promote and search the tail.
    for (n = 4; n < DEPTH; n++)
      add_request(REQ_APPEND, KEY_W'(16'h1000 + n), PAY_W'(n * 17));
    add_request(REQ_APPEND, 16'h7777, 8'h77);
    add_request(REQ_SEARCH, KEY_W'(16'h1000 + DEPTH - 1), 8'h00);
    add_request(REQ_PROMOTE, KEY_W'(16'h1000 + DEPTH - 1), 8'h00);

    filling = 1'b1;
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 40 == 0) filling = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 99);
      if (roll < (filling ? 55 : 10)) kind = REQ_APPEND;
      else if (roll < 65) kind = REQ_POP;
      else if (roll < 83) kind = REQ_PROMOTE;
      else kind = REQ_SEARCH;
      add_request(kind, pick_key(), PAY_W'($urandom_range(0, 255)));
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (request_backlog.size() != 0 || req_valid) @(posedge clk);
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/fqp_pkg.sv
rtl/core/fqp_ram.sv
rtl/core/fqp_ctrl.sv
rtl/core/fqp_dpath.sv
rtl/core/fifo_queue_with_promote_unit.sv
verif/fifo_queue_with_promote_unit_test.sv
